>>> hw/rtl/satq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// satq_pkg
// Shared types, sizes and helpers for the summed-area table query block.
// ---------------------------------------------------------------------------
package satq_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Field widths fixed by the interface
  localparam int DIM_W   = 7;
  localparam int IDX_W   = 6;
  localparam int PIX_W   = 16;
  localparam int SUM_W   = 32;
  localparam int CFG_A_W = 1;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_A_W-1:0] REG_NUM_COLS = 1'b1;

  // Request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Status codes
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_issue;   // load accepted: advance position, read entry above
    logic ld_write;   // write the new table entry
    logic q_issue;    // query accepted: check bounds, read first pair
    logic q_second;   // read second pair, fold first pair
    logic q_finish;   // form the sum and strobe the result
  } satq_cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > max_v) r = max_v;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

endpackage

>>> hw/rtl/satq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// satq_ctrl
// Sequencer: steps a load through read/write and a query through a first
// read, a second read and a finish.
// ---------------------------------------------------------------------------
module satq_ctrl
  import satq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      req_type_i,
  output logic      busy_o,
  output satq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LD_WR,
    S_Q_RD2,
    S_Q_FIN
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   accept;

  assign accept = start_i & ~busy_q;
  assign busy_o = busy_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.ld_issue = accept & (req_type_i == REQ_LOAD);
    cmd_o.q_issue  = accept & (req_type_i == REQ_QUERY);
    cmd_o.ld_write = (state_q == S_LD_WR);
    cmd_o.q_second = (state_q == S_Q_RD2);
    cmd_o.q_finish = (state_q == S_Q_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            busy_q  <= 1'b1;
            state_q <= (req_type_i == REQ_LOAD) ? S_LD_WR : S_Q_RD2;
          end
        end
        S_LD_WR: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        S_Q_RD2: begin
          state_q <= S_Q_FIN;
        end
        S_Q_FIN: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        default: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/satq_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// satq_dp
// Datapath: size registers, load position, row running sum, the table
// memory and the inclusion-exclusion adder.
// ---------------------------------------------------------------------------
module satq_dp
  import satq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  satq_cmd_t                cmd_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_A_W-1:0]       cfg_index_i,
  input  logic [DIM_W-1:0]         cfg_data_i,
  input  logic                     start_of_matrix_i,
  input  logic signed [PIX_W-1:0]  pixel_value_i,
  input  logic [IDX_W-1:0]         row_first_i,
  input  logic [IDX_W-1:0]         col_first_i,
  input  logic [IDX_W-1:0]         row_last_i,
  input  logic [IDX_W-1:0]         col_last_i,
  output logic                     done_o,
  output logic signed [SUM_W-1:0]  region_sum_o,
  output logic                     status_o
);

  localparam logic [DIM_W-1:0] MAX_R = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] MAX_C = DIM_W'(MAX_COLS);

  // control state
  logic [DIM_W-1:0] num_rows_q, num_cols_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [SUM_W-1:0] rsum_q;
  logic             ready_q;
  logic             done_q;

  // payload
  logic [SUM_W-1:0]  mem [DEPTH];
  logic [SUM_W-1:0]  rd_a_q, rd_b_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [SUM_W-1:0]  wsum_q;
  logic              above_zero_q;
  logic [ROW_W-1:0]  qr1_q;
  logic [COL_W-1:0]  qc1_q;
  logic [ROW_W-1:0]  qr2_q;
  logic              zb_q, zc_q, zd_q, err_q;
  logic [SUM_W-1:0]  pa_q, sum_q;
  logic              status_q;

  logic              restart;
  logic [ROW_W-1:0]  row_eff;
  logic [COL_W-1:0]  col_eff;
  logic [SUM_W-1:0]  rsum_eff, new_sum;
  logic              last_col, last_row;
  logic [ROW_W-1:0]  r1, r2;
  logic [COL_W-1:0]  c1, c2;
  logic              q_err;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic [SUM_W-1:0]  above;

  // Out-of-size position means the previous matrix completed or sizes changed
  assign restart  = start_of_matrix_i | (DIM_W'(row_q) >= num_rows_q)
                  | (DIM_W'(col_q) >= num_cols_q);
  assign row_eff  = restart ? '0 : row_q;
  assign col_eff  = restart ? '0 : col_q;
  assign rsum_eff = restart ? '0 : rsum_q;
  assign new_sum  = rsum_eff + SUM_W'(pixel_value_i);
  assign last_col = (DIM_W'(col_eff) + DIM_W'(1)) >= num_cols_q;
  assign last_row = (DIM_W'(row_eff) + DIM_W'(1)) >= num_rows_q;

  assign r1 = ROW_W'(row_first_i);
  assign r2 = ROW_W'(row_last_i);
  assign c1 = COL_W'(col_first_i);
  assign c2 = COL_W'(col_last_i);

  assign q_err = ~ready_q | (row_first_i > row_last_i) | (col_first_i > col_last_i)
               | (DIM_W'(row_last_i) >= num_rows_q) | (DIM_W'(col_last_i) >= num_cols_q);

  // index minus one wraps on a zero bound; such reads are masked later
  always_comb begin
    if (cmd_i.q_second) begin
      addr_a = addr_of(qr2_q, qc1_q - COL_W'(1));
      addr_b = addr_of(qr1_q - ROW_W'(1), qc1_q - COL_W'(1));
    end else if (cmd_i.q_issue) begin
      addr_a = addr_of(r2, c2);
      addr_b = addr_of(r1 - ROW_W'(1), c2);
    end else begin
      addr_a = addr_of(row_eff - ROW_W'(1), col_eff);
      addr_b = addr_a;
    end
  end

  assign above = above_zero_q ? '0 : rd_a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_write) begin
      mem[wr_addr_q] <= wsum_q + above;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= clamp_dim(DIM_W'(64), MAX_R);
      num_cols_q <= clamp_dim(DIM_W'(64), MAX_C);
      row_q      <= '0;
      col_q      <= '0;
      rsum_q     <= '0;
      ready_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.q_finish;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_NUM_ROWS: num_rows_q <= clamp_dim(cfg_data_i, MAX_R);
          REG_NUM_COLS: num_cols_q <= clamp_dim(cfg_data_i, MAX_C);
          default: ;
        endcase
        row_q   <= '0;
        col_q   <= '0;
        rsum_q  <= '0;
        ready_q <= 1'b0;
      end else if (cmd_i.ld_issue) begin
        if (row_eff == '0 && col_eff == '0) ready_q <= 1'b0;
        if (last_col) begin
          col_q  <= '0;
          rsum_q <= '0;
          if (last_row) begin
            row_q   <= '0;
            ready_q <= 1'b1;
          end else begin
            row_q <= row_eff + ROW_W'(1);
          end
        end else begin
          col_q  <= col_eff + COL_W'(1);
          rsum_q <= new_sum;
          row_q  <= row_eff;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_issue) begin
      wr_addr_q    <= addr_of(row_eff, col_eff);
      wsum_q       <= new_sum;
      above_zero_q <= (row_eff == '0);
    end
    if (cmd_i.q_issue) begin
      qr1_q <= r1;
      qr2_q <= r2;
      qc1_q <= c1;
      zb_q  <= (r1 == '0);
      zc_q  <= (c1 == '0);
      zd_q  <= (r1 == '0) | (c1 == '0);
      err_q <= q_err;
    end
    if (cmd_i.q_second) begin
      pa_q <= rd_a_q - (zb_q ? '0 : rd_b_q);
    end
    if (cmd_i.q_finish) begin
      sum_q    <= err_q ? '0 : (pa_q - (zc_q ? '0 : rd_a_q) + (zd_q ? '0 : rd_b_q));
      status_q <= err_q ? ST_ERR : ST_OK;
    end
  end

  assign done_o       = done_q;
  assign region_sum_o = sum_q;
  assign status_o     = status_q;

endmodule

>>> hw/rtl/summed_area_table_query_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// summed_area_table_query_top
// Integral image builder with rectangle sum queries.
// ---------------------------------------------------------------------------
//  channel   | handshake                  | word
//  ----------+----------------------------+-----------------------------------
//  request   | start_i & !busy_o          | req_type, start_of_matrix, pixel,
//            |                            | row/col first/last
//  result    | done_o, one cycle strobe   | region_sum_o, status_o
//  config    | cfg_valid_i & cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A load reads the entry above, then writes the new entry; a query does
// two dual-port reads, then one add, its result strobing the cycle after.
// Both sequences are set by the single two-read, one-write table memory.
// Reset sets both sizes to 64 and clears load position and the ready flag;
// the table itself is not cleared; a query before a complete load returns an error.
// The receiver cannot stall.
// ---------------------------------------------------------------------------
module summed_area_table_query_top
  import satq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     req_type_i,
  input  logic                     start_of_matrix_i,
  input  logic signed [PIX_W-1:0]  pixel_value_i,
  input  logic [IDX_W-1:0]         row_first_i,
  input  logic [IDX_W-1:0]         col_first_i,
  input  logic [IDX_W-1:0]         row_last_i,
  input  logic [IDX_W-1:0]         col_last_i,
  output logic                     done_o,
  output logic signed [SUM_W-1:0]  region_sum_o,
  output logic                     status_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_A_W-1:0]       cfg_index_i,
  input  logic [DIM_W-1:0]         cfg_data_i
);

  satq_cmd_t cmd;
  logic      busy;

  assign busy_o      = busy;
  assign cfg_ready_o = ~busy;

  satq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .busy_o     (busy),
    .cmd_o      (cmd)
  );

  satq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_valid_i & ~busy),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .start_of_matrix_i (start_of_matrix_i),
    .pixel_value_i     (pixel_value_i),
    .row_first_i       (row_first_i),
    .col_first_i       (col_first_i),
    .row_last_i        (row_last_i),
    .col_last_i        (col_last_i),
    .done_o            (done_o),
    .region_sum_o      (region_sum_o),
    .status_o          (status_o)
  );

endmodule
